/* rtl/core/axis_exercise_sequencer_assert.svh */
// Assertion macros used by the exercise sequencer top level.
`ifndef AXIS_EXERCISE_SEQUENCER_ASSERT_SVH
`define AXIS_EXERCISE_SEQUENCER_ASSERT_SVH

// Check that a condition holds at every rising clock edge outside reset.
`define AES_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("%m: condition violated");

// Check that a condition in one cycle brings a consequence in the same cycle.
`define AES_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication violated");

// Check that a condition in one cycle brings a consequence in the next cycle.
`define AES_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication violated");

`endif

/* rtl/core/aes_pkg.sv */
// Types, constants and phase tables of the exercise sequencer.
package aes_pkg;

  localparam int unsigned AXIS_COUNT   = 6;
  localparam int unsigned POS_W        = 16;
  localparam int unsigned TICK_W       = 8;
  localparam int unsigned COUNT_W      = 16;
  localparam int unsigned PHASE_W      = 5;
  localparam int unsigned PAIR_W       = 4;
  localparam int unsigned KEY_W        = 6;
  localparam int unsigned AXIS_IDX_W   = 3;
  localparam int unsigned HIST_DEPTH   = 3;
  localparam int unsigned IN_DATA_W    = TICK_W + AXIS_COUNT * POS_W;
  localparam int unsigned OUT_DATA_W   = 16;

  localparam logic [PHASE_W-1:0] PHASE_COUNT = 5'd24;
  localparam logic [PHASE_W-1:0] PHASE_LAST  = 5'd23;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;
  localparam logic [COUNT_W-1:0] STEP_INTERVAL_RESET = 16'd10;

  // Axis slots in the request payload.
  localparam logic [AXIS_IDX_W-1:0] AXIS_TABLE    = 3'd0;
  localparam logic [AXIS_IDX_W-1:0] AXIS_TUBE     = 3'd1;
  localparam logic [AXIS_IDX_W-1:0] AXIS_DETECTOR = 3'd2;
  localparam logic [AXIS_IDX_W-1:0] AXIS_SID      = 3'd3;
  localparam logic [AXIS_IDX_W-1:0] AXIS_BUCKY    = 3'd4;
  localparam logic [AXIS_IDX_W-1:0] AXIS_ANGLE    = 3'd5;

  // Move key codes.
  localparam logic [KEY_W-1:0] KEY_TABLE_UP    = 6'h32;
  localparam logic [KEY_W-1:0] KEY_TUBE_UP     = 6'h22;
  localparam logic [KEY_W-1:0] KEY_TUBE_DOWN   = 6'h20;
  localparam logic [KEY_W-1:0] KEY_DET_DOWN    = 6'h2c;
  localparam logic [KEY_W-1:0] KEY_DET_UP      = 6'h2e;
  localparam logic [KEY_W-1:0] KEY_SID_UP      = 6'h26;
  localparam logic [KEY_W-1:0] KEY_SID_DOWN    = 6'h24;
  localparam logic [KEY_W-1:0] KEY_BUCKY_UP    = 6'h36;
  localparam logic [KEY_W-1:0] KEY_BUCKY_DOWN  = 6'h34;
  localparam logic [KEY_W-1:0] KEY_ANGLE_UP    = 6'h2a;
  localparam logic [KEY_W-1:0] KEY_ANGLE_DOWN  = 6'h28;
  localparam logic [KEY_W-1:0] KEY_TABLE_DOWN  = 6'h30;
  localparam logic [KEY_W-1:0] KEY_NONE        = 6'h00;

  typedef struct packed {
    logic [AXIS_IDX_W-1:0] axis;
    logic [KEY_W-1:0]      key;
    logic                  rising;
  } pair_entry_t;

  typedef struct packed {
    logic [AXIS_COUNT-1:0][POS_W-1:0] pos;
    logic [TICK_W-1:0]                tick_count;
  } in_item_t;

  typedef struct packed {
    logic                  key_valid;
    logic [KEY_W-1:0]      key_code;
    logic [PHASE_W-1:0]    phase;
  } result_t;

  typedef struct packed {
    logic [PHASE_W-1:0]                  phase;
    logic [HIST_DEPTH-1:0][POS_W-1:0]    hist;
    logic [COUNT_W-1:0]                  count;
  } seq_state_t;

  function automatic pair_entry_t pair_lookup(input logic [PAIR_W-1:0] pair);
    pair_entry_t e;
    case (pair)
      4'd0:    e = '{AXIS_TABLE,    KEY_TABLE_UP,   1'b1};
      4'd1:    e = '{AXIS_TUBE,     KEY_TUBE_UP,    1'b1};
      4'd2:    e = '{AXIS_TUBE,     KEY_TUBE_DOWN,  1'b0};
      4'd3:    e = '{AXIS_DETECTOR, KEY_DET_DOWN,   1'b0};
      4'd4:    e = '{AXIS_DETECTOR, KEY_DET_UP,     1'b1};
      4'd5:    e = '{AXIS_SID,      KEY_SID_UP,     1'b1};
      4'd6:    e = '{AXIS_SID,      KEY_SID_DOWN,   1'b0};
      4'd7:    e = '{AXIS_BUCKY,    KEY_BUCKY_UP,   1'b1};
      4'd8:    e = '{AXIS_BUCKY,    KEY_BUCKY_DOWN, 1'b0};
      4'd9:    e = '{AXIS_ANGLE,    KEY_ANGLE_UP,   1'b1};
      4'd10:   e = '{AXIS_ANGLE,    KEY_ANGLE_DOWN, 1'b0};
      4'd11:   e = '{AXIS_TABLE,    KEY_TABLE_DOWN, 1'b0};
      default: e = '{AXIS_TABLE,    KEY_NONE,       1'b0};
    endcase
    return e;
  endfunction

endpackage

/* rtl/core/aes_step.sv */
// Single-pass step logic: interval count, phase advance and sample history.
module aes_step (
  input  aes_pkg::seq_state_t       state,
  input  aes_pkg::in_item_t         item,
  input  logic [15:0]               step_interval,
  output aes_pkg::seq_state_t       state_next,
  output aes_pkg::result_t          result
);
  import aes_pkg::*;

  logic [COUNT_W:0]     sum;
  logic [COUNT_W-1:0]   count_sat;
  logic                 act;
  logic [PAIR_W-1:0]    pair;
  pair_entry_t          entry;
  logic [POS_W-1:0]     reading;
  logic [POS_W:0]       mean_sum;
  logic [POS_W-1:0]     mean;
  logic                 done;

  assign sum       = {1'b0, state.count} + {{(COUNT_W + 1 - TICK_W){1'b0}}, item.tick_count};
  assign count_sat = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
  assign act       = count_sat >= step_interval;
  assign pair      = state.phase[PHASE_W-1:1];
  assign entry     = pair_lookup(pair);
  assign reading   = item.pos[entry.axis];
  assign mean_sum  = {1'b0, state.hist[0]} + {1'b0, state.hist[1]};
  assign mean      = mean_sum[POS_W:1];
  assign done      = entry.rising ? (reading >= mean) : (reading <= mean);

  always_comb begin
    state_next       = state;
    result.key_valid = 1'b0;
    result.key_code  = KEY_NONE;
    state_next.count = act ? '0 : count_sat;
    if (act && (state.phase < PHASE_COUNT)) begin
      if (!state.phase[0]) begin
        result.key_valid   = 1'b1;
        result.key_code    = entry.key;
        state_next.hist[0] = reading;
        state_next.hist[1] = reading;
        state_next.phase   = state.phase + 5'd1;
      end else begin
        state_next.hist[2] = state.hist[1];
        state_next.hist[1] = state.hist[0];
        state_next.hist[0] = reading;
        if (done) begin
          state_next.phase = (state.phase == PHASE_LAST) ? '0 : state.phase + 5'd1;
        end
      end
    end
    result.phase = state_next.phase;
  end

endmodule

/* rtl/core/axis_exercise_sequencer.sv */
// Top level of the exercise sequencer: request register, step logic, result register.
//
//  channel   | direction | handshake                    | payload
//  ----------+-----------+------------------------------+-----------------------------------
//  s_axis    | in        | s_axis_tvalid / s_axis_tready| tick_count, six axis positions
//  m_axis    | out       | m_axis_tvalid / m_axis_tready| key_code, phase; tuser key_valid
//  cfg       | in        | cfg_we                       | step_interval
//
//  One request per cycle while the result is not stalled; each passes from acceptance to
//  result through the request register, then the result register, with the single step logic stage between them.
//  Reset (rst, synchronous) clears phase, history and count and loads step_interval 10.
//  A stalled result holds both registers; a new request is still taken while the
//  request register is empty or moving on.
`include "axis_exercise_sequencer_assert.svh"

module axis_exercise_sequencer (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [7:0] tick_count, [23:8] table_pos, [39:24] tube_pos, [55:40] detector_pos,
  // [71:56] sid_pos, [87:72] bucky_pos, [103:88] angle_pos
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [5:0] key_code, [10:6] phase, [15:11] zero
  output logic [15:0]  m_axis_tdata,
  // [0] key_valid
  output logic         m_axis_tuser,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata
);
  import aes_pkg::*;

  logic                in_valid;
  in_item_t            in_item;
  seq_state_t          state;
  seq_state_t          state_next;
  result_t             step_result;
  result_t             out_item;
  logic                out_valid;
  logic [COUNT_W-1:0]  step_interval;
  logic                advance;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  aes_step u_step (
    .state         (state),
    .item          (in_item),
    .step_interval (step_interval),
    .state_next    (state_next),
    .result        (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      step_interval <= STEP_INTERVAL_RESET;
    end else if (cfg_we) begin
      step_interval <= cfg_wdata;
    end
  end

  // Request register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.tick_count <= s_axis_tdata[TICK_W-1:0];
      for (int i = 0; i < AXIS_COUNT; i++) begin
        in_item.pos[i] <= s_axis_tdata[TICK_W + i*POS_W +: POS_W];
      end
    end
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= step_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_item.key_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W - KEY_W - PHASE_W){1'b0}}, out_item.phase,
                          out_item.key_code};

  `AES_ASSERT_ALWAYS(a_phase_range, clk, rst, state.phase < PHASE_COUNT)
  `AES_ASSERT_NEXT(a_result_drains, clk, rst, out_valid && m_axis_tready && !advance, !out_valid)
  `AES_ASSERT_IMPLIES(a_key_odd_phase, clk, rst, out_valid && out_item.key_valid, out_item.key_code != KEY_NONE && out_item.phase[0])
  `AES_ASSERT_IMPLIES(a_no_key_zero, clk, rst, out_valid && !out_item.key_valid, out_item.key_code == KEY_NONE)

endmodule

/* bench/axis_exercise_sequencer_test.sv */
// Self-checking bench for the exercise sequencer: predicted step results against the stream output.
`timescale 1ns / 1ps

module axis_exercise_sequencer_test;
  import aes_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  class key_scoreboard;
    localparam int SHOW_MAX = 10;

    logic [COUNT_W-1:0] interval;
    logic [COUNT_W-1:0] count;
    logic [PHASE_W-1:0] phase;
    logic [POS_W-1:0]   hist [HIST_DEPTH];
    result_t            expected_steps [$];
    int                 mismatches;
    int                 requests;
    int                 keys;
    int                 laps;

    function new();
      interval = STEP_INTERVAL_RESET;
      count = '0;
      phase = '0;
      foreach (hist[i]) hist[i] = '0;
      mismatches = 0;
      requests = 0;
      keys = 0;
      laps = 0;
    endfunction

    function void set_interval(input logic [COUNT_W-1:0] value);
      interval = value;
    endfunction

    // mean that the next odd-phase reading is compared against
    function logic [POS_W-1:0] boundary();
      logic [POS_W:0] total;
      total = hist[0] + hist[1];
      return total[POS_W:1];
    endfunction

    function void pair_info(input logic [PAIR_W-1:0] pair, output logic [AXIS_IDX_W-1:0] axis,
                            output logic [KEY_W-1:0] key, output bit rising);
      case (pair)
        4'd0:  begin axis = AXIS_TABLE;    key = KEY_TABLE_UP;   rising = 1'b1; end
        4'd1:  begin axis = AXIS_TUBE;     key = KEY_TUBE_UP;    rising = 1'b1; end
        4'd2:  begin axis = AXIS_TUBE;     key = KEY_TUBE_DOWN;  rising = 1'b0; end
        4'd3:  begin axis = AXIS_DETECTOR; key = KEY_DET_DOWN;   rising = 1'b0; end
        4'd4:  begin axis = AXIS_DETECTOR; key = KEY_DET_UP;     rising = 1'b1; end
        4'd5:  begin axis = AXIS_SID;      key = KEY_SID_UP;     rising = 1'b1; end
        4'd6:  begin axis = AXIS_SID;      key = KEY_SID_DOWN;   rising = 1'b0; end
        4'd7:  begin axis = AXIS_BUCKY;    key = KEY_BUCKY_UP;   rising = 1'b1; end
        4'd8:  begin axis = AXIS_BUCKY;    key = KEY_BUCKY_DOWN; rising = 1'b0; end
        4'd9:  begin axis = AXIS_ANGLE;    key = KEY_ANGLE_UP;   rising = 1'b1; end
        4'd10: begin axis = AXIS_ANGLE;    key = KEY_ANGLE_DOWN; rising = 1'b0; end
        default: begin axis = AXIS_TABLE;  key = KEY_TABLE_DOWN; rising = 1'b0; end
      endcase
    endfunction

    function void note_request(input in_item_t req);
      logic [COUNT_W:0]      total;
      logic [POS_W:0]        pair_sum;
      logic [POS_W-1:0]      reading;
      logic [POS_W-1:0]      mean;
      logic [AXIS_IDX_W-1:0] axis;
      logic [KEY_W-1:0]      key;
      bit                    rising;
      bit                    done;
      result_t               r;
      requests++;
      r.key_valid = 1'b0;
      r.key_code = KEY_NONE;
      total = count + req.tick_count;
      count = (total > COUNT_MAX) ? COUNT_MAX : total[COUNT_W-1:0];
      if (count >= interval) begin
        count = '0;
        if (phase < PHASE_COUNT) begin
          pair_info(phase[PHASE_W-1:1], axis, key, rising);
          reading = req.pos[axis];
          if (!phase[0]) begin
            r.key_valid = 1'b1;
            r.key_code = key;
            hist[0] = reading;
            hist[1] = reading;
            phase = phase + 1'b1;
            keys++;
          end else begin
            hist[2] = hist[1];
            hist[1] = hist[0];
            hist[0] = reading;
            pair_sum = hist[1] + hist[2];
            mean = pair_sum[POS_W:1];
            done = rising ? (reading >= mean) : (reading <= mean);
            if (done) begin
              if (phase == PHASE_LAST) begin
                phase = '0;
                laps++;
              end else begin
                phase = phase + 1'b1;
              end
            end
          end
        end
      end
      r.phase = phase;
      expected_steps.push_back(r);
    endfunction

    function void note_failure(input string msg);
      mismatches++;
      if (mismatches <= SHOW_MAX) $display("[%0t] %s", $time, msg);
    endfunction

    function void check_result(input logic key_valid, input logic [KEY_W-1:0] key_code,
                               input logic [PHASE_W-1:0] phase_out);
      result_t e;
      if (expected_steps.size() == 0) begin
        note_failure($sformatf("result with no request outstanding: valid=%0b key=%h phase=%0d",
                               key_valid, key_code, phase_out));
        return;
      end
      e = expected_steps.pop_front();
      if (e.key_valid !== key_valid || e.key_code !== key_code || e.phase !== phase_out)
        note_failure($sformatf("expected valid=%0b key=%h phase=%0d, got valid=%0b key=%h phase=%0d",
                               e.key_valid, e.key_code, e.phase, key_valid, key_code, phase_out));
    endfunction

    function void final_check();
      if (expected_steps.size() != 0)
        note_failure($sformatf("%0d results never arrived", expected_steps.size()));
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_we;
  logic [COUNT_W-1:0]    cfg_wdata;

  key_scoreboard sb;
  bit            calm;
  int            cycle_count = 0;
  int            settings_used = 1;

  axis_exercise_sequencer dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("axis_exercise_sequencer_test failed");
      $finish;
    end
  end

  function automatic in_item_t flat_request(input logic [TICK_W-1:0] tick,
                                            input logic [POS_W-1:0] level);
    in_item_t req;
    req.tick_count = tick;
    for (int a = 0; a < AXIS_COUNT; a++) req.pos[a] = level;
    return req;
  endfunction

  function automatic in_item_t random_request(input int tick_lo, input int tick_hi);
    in_item_t        req;
    logic [POS_W-1:0] level;
    int              style;
    req.tick_count = TICK_W'($urandom_range(tick_lo, tick_hi));
    level = sb.boundary();
    style = $urandom_range(0, 9);
    for (int a = 0; a < AXIS_COUNT; a++) begin
      case (style)
        0, 1:    req.pos[a] = level;
        2:       req.pos[a] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        3:       req.pos[a] = level + POS_W'($urandom_range(0, 2)) - 1'b1;
        default: req.pos[a] = POS_W'($urandom);
      endcase
    end
    return req;
  endfunction

  task automatic send_request(input in_item_t req);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= req;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(req);
  endtask

  // drop valid and hold until every result is back
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_steps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_interval(input logic [COUNT_W-1:0] value);
    settle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_interval(value);
    settings_used++;
  endtask

  task automatic run_segment(input int n, input int tick_lo, input int tick_hi,
                             input bit pause_mid);
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      if (pause_mid && i == n / 2) settle();
      send_request(random_request(tick_lo, tick_hi));
    end
  endtask

  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      sb.check_result(m_axis_tuser, m_axis_tdata[KEY_W-1:0],
                      m_axis_tdata[KEY_W+PHASE_W-1:KEY_W]);
      @(negedge clk);
    end
  end

  initial begin
    in_item_t req;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    calm = 1'b0;
    sb = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset interval: reach it exactly, fail then pass a rising test, then walk the phases
    for (int i = 0; i < 25; i++) begin
      case (i)
        0:       req = flat_request(8'd0, 16'h0000);
        1:       req = flat_request(8'd9, 16'h0000);
        2:       req = flat_request(8'd1, 16'hFFFF);
        3:       req = flat_request(8'd255, 16'h0000);
        4:       req = flat_request(8'd255, 16'hFFFF);
        default: req = flat_request(8'd255, 16'h8000);
      endcase
      send_request(req);
    end

    write_interval(16'd0);
    run_segment(300, 0, 255, 1'b0);
    write_interval(COUNT_MAX);
    run_segment(650, 200, 255, 1'b0);
    write_interval(16'd1);
    run_segment(300, 0, 3, 1'b1);
    write_interval(COUNT_W'($urandom_range(2, 600)));
    run_segment(300, 0, 255, 1'b0);
    write_interval(STEP_INTERVAL_RESET);
    run_segment(450, 0, 255, 1'b0);

    settle();
    sb.final_check();
    $display("Covered %0d requests under %0d step interval settings, zero and full scale included.",
             sb.requests, settings_used);
    $display("%0d move keys issued, %0d full laps through all phases.", sb.keys, sb.laps);
    if (sb.mismatches == 0) begin
      $display("axis_exercise_sequencer_test passed");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("axis_exercise_sequencer_test failed");
    end
    $finish;
  end

endmodule
